// ===== hw/rtl/keyframe_color_gradient_lerp_unit_defines.svh =====
// assertion macros for the keyframe color gradient lerp unit
`ifndef KEYFRAME_COLOR_GRADIENT_LERP_UNIT_DEFINES_SVH
`define KEYFRAME_COLOR_GRADIENT_LERP_UNIT_DEFINES_SVH

// clocked assertion, off while reset is low
`define KCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KCG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/kcg_pkg.sv =====
// package: types, constants and codes of the keyframe color gradient lerp unit
`timescale 1ns / 1ps
`default_nettype none
package kcg_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int DIV_N     = 33;
    localparam int DIV_D     = 17;
    localparam int DIV_CW    = $clog2(DIV_N + 1);
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] REL_MAX   = 17'd131071;
    localparam logic [16:0] FLAT_SPAN = 17'd65;
    localparam logic [31:0] MISS_RESET = 32'hFFFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_MISS_COLOR   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  vertex_index;
        logic [16:0] vertex_time;
        logic [31:0] min_color;
        logic [31:0] max_color;
        logic [15:0] age;
        logic [15:0] life_time;
        logic [16:0] rand_weight;
    } in_item_t;

    typedef struct packed {
        logic [31:0] color;
        logic        in_range;
    } out_item_t;

    typedef struct packed {
        logic [16:0] key_time;
        logic [31:0] min_color;
        logic [31:0] max_color;
    } key_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_REL,
        ST_SCAN,
        ST_DIV_BLEND,
        ST_LERP_EDGE,
        ST_LERP_RAND,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kcg_key_mem.sv =====
// keyframe store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module kcg_key_mem
    import kcg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [KEY_AW-1:0] waddr,
    input  wire key_entry_t        wdata,
    input  wire logic [KEY_AW-1:0] raddr,
    output key_entry_t             rdata
);

    key_entry_t mem [MAX_KEYS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/kcg_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module kcg_div
    import kcg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_N-1:0] dividend,
    input  wire logic [DIV_D-1:0] divisor,
    output logic                  done,
    output logic      [DIV_N-1:0] quotient
);

    logic [DIV_D:0]    rem_reg, rem_next;
    logic [DIV_N-1:0]  quo_reg, quo_next;
    logic [DIV_D-1:0]  div_reg;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_D:0]    shifted;

    always_comb
    begin
        shifted   = {rem_reg[DIV_D-1:0], quo_reg[DIV_N-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
                quo_next = {quo_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CW'(1);
            if (cnt_reg == DIV_CW'(DIV_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/kcg_lerp.sv =====
// four-channel argb lerp: a + floor((b - a) * k / 65536)
`timescale 1ns / 1ps
`default_nettype none
module kcg_lerp
    import kcg_pkg::*;
(
    input  wire logic [31:0] color_a,
    input  wire logic [31:0] color_b,
    input  wire logic [16:0] weight,
    output logic      [31:0] color_q
);

    always_comb
    begin
        logic signed [9:0]  d;
        logic signed [27:0] p;
        logic signed [27:0] q;
        color_q = '0;
        for (int c = 0; c < 4; c++)
        begin
            d = $signed({2'b00, color_b[c*8 +: 8]}) - $signed({2'b00, color_a[c*8 +: 8]});
            p = d * $signed({1'b0, weight});
            q = p >>> 16;
            color_q[c*8 +: 8] = color_a[c*8 +: 8] + q[7:0];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/keyframe_color_gradient_lerp_unit.sv =====
// top level of the keyframe color gradient lerp unit; a write item gives no result
// query: straight to the miss color on zero lifetime or short table, else relative time
//   divide, scan to the bracketing segment, blend divide off flat segments, edge lerp, random lerp
// and done, the scan running to the last segment on a miss, plus any wait on out_ready; one query
//   in flight, the next item is taken at the edge after the result enters the output register
// reset: async active low, clears control, vertex_count to 0, miss_color to all ones
`timescale 1ns / 1ps
`default_nettype none
module keyframe_color_gradient_lerp_unit
    import kcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    // configuration registers
    logic [4:0]  vertex_count_reg;
    logic [31:0] miss_color_reg;

    // control and datapath registers
    state_t      state_reg, state_next;
    logic [16:0] kr_reg, kr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0] rel_reg, rel_next;
    key_entry_t  lo_reg, lo_next;
    key_entry_t  hi_reg, hi_next;
    logic [16:0] blend_reg, blend_next;
    logic [31:0] mn_reg, mn_next;
    logic [31:0] mx_reg, mx_next;
    logic [31:0] res_color_reg, res_color_next;
    logic        res_hit_reg, res_hit_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    // memory, divider and lerp hookup
    logic              mem_we;
    key_entry_t        mem_wdata;
    logic [KEY_AW-1:0] mem_raddr;
    key_entry_t        mem_rdata;
    logic              div_start;
    logic [DIV_N-1:0]  div_dividend;
    logic [DIV_D-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_N-1:0]  div_quo;
    logic [31:0]       la_a, la_b, la_q;
    logic [16:0]       la_k;
    logic [31:0]       lb_q;

    logic        accept;
    logic [16:0] span;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // keyframe write, slots past the table are dropped
    assign mem_we    = accept && (in_data.operation == OP_WRITE)
                       && (32'(in_data.vertex_index) < MAX_KEYS);
    assign mem_wdata = '{key_time:  in_data.vertex_time,
                         min_color: in_data.min_color,
                         max_color: in_data.max_color};

    // scan issues entry cnt+1 while entry cnt is at the read port
    assign mem_raddr = (state_reg == ST_SCAN) ? KEY_AW'(cnt_reg + CNT_W'(1)) : '0;

    assign span = mem_rdata.key_time - lo_reg.key_time;

    kcg_key_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (KEY_AW'(in_data.vertex_index)),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    kcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // lane a does min edge, then the random blend; lane b does max edge
    always_comb
    begin
        if (state_reg == ST_LERP_RAND)
        begin
            la_a = mn_reg;
            la_b = mx_reg;
            la_k = kr_reg;
        end
        else
        begin
            la_a = lo_reg.min_color;
            la_b = hi_reg.min_color;
            la_k = blend_reg;
        end
    end

    kcg_lerp u_lerp_a (
        .color_a (la_a),
        .color_b (la_b),
        .weight  (la_k),
        .color_q (la_q)
    );

    kcg_lerp u_lerp_b (
        .color_a (lo_reg.max_color),
        .color_b (hi_reg.max_color),
        .weight  (blend_reg),
        .color_q (lb_q)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kr_next        = kr_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        rel_next       = rel_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        blend_next     = blend_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        res_color_next = res_color_reg;
        res_hit_next   = res_hit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_dividend   = {1'b0, in_data.age, 16'd0};
        div_divisor    = {1'b0, in_data.life_time};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.operation == OP_QUERY))
                begin
                    kr_next = (in_data.rand_weight > ONE_Q16) ? ONE_Q16 : in_data.rand_weight;
                    if (32'(vertex_count_reg) > MAX_KEYS)
                    begin
                        count_next = CNT_W'(MAX_KEYS);
                    end
                    else
                    begin
                        count_next = CNT_W'(vertex_count_reg);
                    end
                    res_color_next = miss_color_reg;
                    res_hit_next   = 1'b0;
                    // zero lifetime or short table: straight to the miss color
                    if ((in_data.life_time == 16'd0) || (count_next < CNT_W'(2)))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_REL;
                    end
                end
            end
            ST_DIV_REL:
            begin
                if (div_done)
                begin
                    if (div_quo > DIV_N'(REL_MAX))
                    begin
                        rel_next = REL_MAX;
                    end
                    else
                    begin
                        rel_next = div_quo[16:0];
                    end
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    lo_next  = mem_rdata;
                    cnt_next = CNT_W'(1);
                end
                else if ((lo_reg.key_time <= rel_reg) && (rel_reg <= mem_rdata.key_time))
                begin
                    hi_next = mem_rdata;
                    if (span > FLAT_SPAN)
                    begin
                        div_start    = 1'b1;
                        div_dividend = {rel_reg - lo_reg.key_time, 16'd0};
                        div_divisor  = span;
                        state_next   = ST_DIV_BLEND;
                    end
                    else
                    begin
                        blend_next = '0;
                        state_next = ST_LERP_EDGE;
                    end
                end
                else if (CNT_W'(cnt_reg + CNT_W'(1)) == count_reg)
                begin
                    // no bracketing segment
                    state_next = ST_DONE;
                end
                else
                begin
                    lo_next  = mem_rdata;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV_BLEND:
            begin
                if (div_done)
                begin
                    blend_next = div_quo[16:0];
                    state_next = ST_LERP_EDGE;
                end
            end
            ST_LERP_EDGE:
            begin
                mn_next    = la_q;
                mx_next    = lb_q;
                state_next = ST_LERP_RAND;
            end
            ST_LERP_RAND:
            begin
                res_color_next = la_q;
                res_hit_next   = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{color: res_color_reg, in_range: res_hit_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= 5'd0;
            miss_color_reg   <= MISS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VERTEX_COUNT: vertex_count_reg <= cfg_data[4:0];
                    REG_MISS_COLOR:   miss_color_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kr_reg        <= kr_next;
        count_reg     <= count_next;
        cnt_reg       <= cnt_next;
        rel_reg       <= rel_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        blend_reg     <= blend_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        res_color_reg <= res_color_next;
        res_hit_reg   <= res_hit_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/kcg_checker.sv =====
// port-level checker for the keyframe color gradient lerp unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_color_gradient_lerp_unit_defines.svh"
module kcg_checker
    import kcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire in_item_t    in_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire out_item_t   out_data,
    input  wire logic        cfg_we
);

    `KCG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stall")
    `KCG_ASSERT(a_query_busy, in_valid && in_ready && in_data.operation == OP_QUERY |=> !in_ready, "busy")
    `KCG_ASSERT(a_write_quick, in_valid && in_ready && in_data.operation == OP_WRITE |=> in_ready, "write")
    `KCG_ASSERT(a_cfg_quiet, cfg_we |-> in_ready && !out_valid, "register write with an item in flight")
    `KCG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "item shown during reset")

endmodule

bind keyframe_color_gradient_lerp_unit kcg_checker u_kcg_checker (.*);
`default_nettype wire
